// File: rtl/hmbs_pkg.sv
// Package for the HTTP message boundary scanner: status and flag codes,
// word types for the two channels and the fixed match table.
// No dependencies.
package hmbs_pkg;

   localparam int MAX_DIGITS_DEF = 7;

   // result status codes
   localparam logic [1:0] ST_SEARCH = 2'd0;
   localparam logic [1:0] ST_FLUSH  = 2'd1;
   localparam logic [1:0] ST_SKIP   = 2'd2;
   localparam logic [1:0] ST_ABORT  = 2'd3;

   // message flags
   localparam logic [7:0] F_REQ = 8'h01;
   localparam logic [7:0] F_RSP = 8'h02;
   localparam logic [7:0] F_LEN = 8'h04;
   localparam logic [7:0] F_CHK = 8'h08;
   localparam logic [7:0] F_NOB = 8'h10;
   localparam logic [7:0] F_NOF = 8'h20;
   localparam logic [7:0] F_V0  = 8'h40;
   localparam logic [7:0] F_V1  = 8'h80;

   // table events
   localparam logic [7:0] EV_ANY = 8'd0;
   localparam logic [7:0] EV_EOL = 8'd10;
   localparam logic [7:0] EV_LWS = 8'd32;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam logic [6:0] TBL_SIZE    = 7'd69;
   localparam logic [6:0] RSP_START   = 7'd0;
   localparam logic [6:0] REQ_START   = 7'd10;
   localparam logic [6:0] CHUNK_START = 7'd61;
   localparam logic [6:0] B9          = 7'd67;

   // line phases
   localparam logic [2:0] LP_TEXT   = 3'd0;
   localparam logic [2:0] LP_EOL    = 3'd1;
   localparam logic [2:0] LP_TRL    = 3'd3;
   localparam logic [2:0] LP_TRLTXT = 3'd4;

   // table actions
   localparam logic [3:0] A_NOP  = 4'd0;
   localparam logic [3:0] A_V0   = 4'd1;
   localparam logic [3:0] A_V1   = 4'd2;
   localparam logic [3:0] A_NOB  = 4'd3;
   localparam logic [3:0] A_RSP  = 4'd4;
   localparam logic [3:0] A_DDIG = 4'd5;
   localparam logic [3:0] A_HDIG = 4'd6;
   localparam logic [3:0] A_DEND = 4'd7;
   localparam logic [3:0] A_HEND = 4'd8;
   localparam logic [3:0] A_CHK  = 4'd9;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       from_client;
      logic       new_session;
      logic       segment_last;
      logic       peer_head_seen;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] flush_offset;
      logic        head_request_flush;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] ev;
      logic [6:0] hit;
      logic [6:0] miss;
      logic [3:0] act;
   } tbl_entry_type;

   function automatic tbl_entry_type tbl_entry(logic [6:0] idx);
      tbl_entry_type e;
      case (idx)
         7'd0:  e = '{"H", 7'd1, 7'd65, A_NOP};
         7'd1:  e = '{"T", 7'd2, B9, A_NOP};
         7'd2:  e = '{"T", 7'd3, B9, A_NOP};
         7'd3:  e = '{"P", 7'd4, B9, A_NOP};
         7'd4:  e = '{"/", 7'd5, B9, A_NOP};
         7'd5:  e = '{"1", 7'd6, B9, A_NOP};
         7'd6:  e = '{".", 7'd7, B9, A_NOP};
         7'd7:  e = '{"0", 7'd9, 7'd8, A_V0};
         7'd8:  e = '{"1", 7'd9, B9, A_V1};
         7'd9:  e = '{EV_LWS, B9, B9, A_RSP};
         7'd10: e = '{"H", 7'd11, 7'd15, A_NOP};
         7'd11: e = '{"E", 7'd12, B9, A_NOP};
         7'd12: e = '{"A", 7'd13, B9, A_NOP};
         7'd13: e = '{"D", 7'd14, B9, A_NOP};
         7'd14: e = '{EV_LWS, B9, B9, A_NOB};
         7'd15: e = '{"C", 7'd16, 7'd32, A_NOP};
         7'd16: e = '{"O", 7'd17, B9, A_NOP};
         7'd17: e = '{"N", 7'd18, B9, A_NOP};
         7'd18: e = '{"T", 7'd19, B9, A_NOP};
         7'd19: e = '{"E", 7'd20, B9, A_NOP};
         7'd20: e = '{"N", 7'd21, B9, A_NOP};
         7'd21: e = '{"T", 7'd22, B9, A_NOP};
         7'd22: e = '{"-", 7'd23, B9, A_NOP};
         7'd23: e = '{"L", 7'd24, B9, A_NOP};
         7'd24: e = '{"E", 7'd25, B9, A_NOP};
         7'd25: e = '{"N", 7'd26, B9, A_NOP};
         7'd26: e = '{"G", 7'd27, B9, A_NOP};
         7'd27: e = '{"T", 7'd28, B9, A_NOP};
         7'd28: e = '{"H", 7'd29, B9, A_NOP};
         7'd29: e = '{EV_LWS, 7'd29, 7'd30, A_NOP};
         7'd30: e = '{":", 7'd31, B9, A_NOP};
         7'd31: e = '{EV_LWS, 7'd31, 7'd59, A_NOP};
         7'd32: e = '{"T", 7'd33, B9, A_NOP};
         7'd33: e = '{"R", 7'd34, B9, A_NOP};
         7'd34: e = '{"A", 7'd35, B9, A_NOP};
         7'd35: e = '{"N", 7'd36, B9, A_NOP};
         7'd36: e = '{"S", 7'd37, B9, A_NOP};
         7'd37: e = '{"F", 7'd38, B9, A_NOP};
         7'd38: e = '{"E", 7'd39, B9, A_NOP};
         7'd39: e = '{"R", 7'd40, B9, A_NOP};
         7'd40: e = '{"-", 7'd41, B9, A_NOP};
         7'd41: e = '{"E", 7'd42, B9, A_NOP};
         7'd42: e = '{"N", 7'd43, B9, A_NOP};
         7'd43: e = '{"C", 7'd44, B9, A_NOP};
         7'd44: e = '{"O", 7'd45, B9, A_NOP};
         7'd45: e = '{"D", 7'd46, B9, A_NOP};
         7'd46: e = '{"I", 7'd47, B9, A_NOP};
         7'd47: e = '{"N", 7'd48, B9, A_NOP};
         7'd48: e = '{"G", 7'd49, B9, A_NOP};
         7'd49: e = '{EV_LWS, 7'd49, 7'd50, A_NOP};
         7'd50: e = '{":", 7'd51, B9, A_NOP};
         7'd51: e = '{EV_LWS, 7'd51, 7'd52, A_NOP};
         7'd52: e = '{"C", 7'd53, B9, A_NOP};
         7'd53: e = '{"H", 7'd54, B9, A_NOP};
         7'd54: e = '{"U", 7'd55, B9, A_NOP};
         7'd55: e = '{"N", 7'd56, B9, A_NOP};
         7'd56: e = '{"K", 7'd57, B9, A_NOP};
         7'd57: e = '{"E", 7'd58, B9, A_NOP};
         7'd58: e = '{"D", B9, B9, A_CHK};
         7'd59: e = '{EV_EOL, 7'd15, 7'd60, A_DEND};
         7'd60: e = '{EV_ANY, 7'd59, 7'd59, A_DDIG};
         7'd61: e = '{EV_EOL, 7'd63, 7'd62, A_HEND};
         7'd62: e = '{EV_ANY, 7'd61, 7'd61, A_HDIG};
         7'd63: e = '{EV_EOL, 7'd61, 7'd64, A_NOP};
         7'd64: e = '{EV_ANY, 7'd63, 7'd63, A_NOP};
         7'd65: e = '{EV_LWS, 7'd0, 7'd66, A_NOP};
         7'd66: e = '{EV_EOL, 7'd0, 7'd68, A_NOP};
         7'd67: e = '{EV_EOL, 7'd15, 7'd68, A_NOP};
         default: e = '{EV_ANY, B9, B9, A_NOP};
      endcase
      return e;
   endfunction

endpackage

// File: rtl/hmbs_req_if.sv
// Input channel of the HTTP message boundary scanner: one byte word.
// Depends on nothing.
interface hmbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       from_client;
   logic       new_session;
   logic       segment_last;
   logic       peer_head_seen;

   modport source(output valid, byte_value, from_client, new_session, segment_last,
                  peer_head_seen, input ready);
   modport sink(input valid, byte_value, from_client, new_session, segment_last,
                peer_head_seen, output ready);
endinterface

// File: rtl/hmbs_rsp_if.sv
// Result channel of the HTTP message boundary scanner: one status word.
// Depends on nothing.
interface hmbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] flush_offset;
   logic        head_request_flush;

   modport source(output valid, status, flush_offset, head_request_flush, input ready);
   modport sink(input valid, status, flush_offset, head_request_flush, output ready);
endinterface

// File: rtl/http_message_boundary_scanner_top.sv
// HTTP message boundary scanner: one direction of a stream, one byte per word.
// Channels req_chan (byte words in) and rsp_chan (one status word per byte).
// csr_wr_en/csr_wr_data write byte_cap; write it only while the block is idle.
// A byte word is held in the input register, the scan core then walks
// the match table and updates the message state, and the status
// word is held in the result register until rsp_chan takes it.
// Throughput is one byte per cycle while rsp_chan does not stall; the critical
// path is the table walk (up to two events per byte) plus the length digit add.
// Reset clears the message state to the response start, zeros the byte
// counter and byte_cap, and empties both registers.
// If rsp_chan stalls, the result register holds its word, one more byte waits
// in the input register, and req_chan.ready drops until the result is taken.
// Depends on hmbs_pkg, hmbs_req_if, hmbs_rsp_if, hmbs_input_reg, hmbs_scan_core.
module http_message_boundary_scanner_top #(
   parameter int MAX_DIGITS = hmbs_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hmbs_req_if.sink    req_chan,
   hmbs_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   hmbs_pkg::req_word_type in_word, stage_word;
   hmbs_pkg::rsp_word_type out_word;
   logic                   stage_valid, stage_take;

   assign in_word.byte_value     = req_chan.byte_value;
   assign in_word.from_client    = req_chan.from_client;
   assign in_word.new_session    = req_chan.new_session;
   assign in_word.segment_last   = req_chan.segment_last;
   assign in_word.peer_head_seen = req_chan.peer_head_seen;

   hmbs_input_reg u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (in_word),
      .out_valid (stage_valid),
      .out_take  (stage_take),
      .out_word  (stage_word)
   );

   hmbs_scan_core #(.MAX_DIGITS(MAX_DIGITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (stage_valid),
      .in_take     (stage_take),
      .in_word     (stage_word),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_word    (out_word)
   );

   assign rsp_chan.status             = out_word.status;
   assign rsp_chan.flush_offset       = out_word.flush_offset;
   assign rsp_chan.head_request_flush = out_word.head_request_flush;
endmodule

// File: rtl/hmbs_input_reg.sv
// Input register stage: holds one accepted byte word for the scan core.
// Depends on hmbs_pkg.
module hmbs_input_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hmbs_pkg::req_word_type in_word,
   output logic                  out_valid,
   input  logic                  out_take,
   output hmbs_pkg::req_word_type out_word
);
   logic                   vld_ff, vld_in;
   hmbs_pkg::req_word_type word_ff;

   assign in_ready  = !vld_ff || out_take;
   assign out_valid = vld_ff;
   assign out_word  = word_ff;

   always_comb begin
      vld_in = vld_ff;
      if (in_valid && in_ready) vld_in = 1'b1;
      else if (out_take) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end
endmodule

// File: rtl/hmbs_scan_core.sv
// Scan core: per-message state, match table walk, length digits, byte cap
// and the result register. Depends on hmbs_pkg.
module hmbs_scan_core #(
   parameter int MAX_DIGITS = hmbs_pkg::MAX_DIGITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic                   in_valid,
   output logic                   in_take,
   input  hmbs_pkg::req_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hmbs_pkg::rsp_word_type out_word
);
   localparam int DCW = $clog2(MAX_DIGITS + 1);

   typedef struct packed {
      logic [6:0]     ms;
      logic [2:0]     lp;
      logic [7:0]     fl;
      logic [31:0]    len;
      logic [DCW-1:0] dc;
      logic           ne;
   } ctx_type;

   function automatic ctx_type restart(logic client);
      ctx_type y;
      y     = '0;
      y.ms  = client ? hmbs_pkg::REQ_START : hmbs_pkg::RSP_START;
      y.fl  = client ? hmbs_pkg::F_REQ : hmbs_pkg::F_RSP;
      return y;
   endfunction

   function automatic ctx_type take_digit(ctx_type x, logic [7:0] c, logic hex);
      ctx_type     y;
      logic [4:0]  d;
      logic        dv;
      logic [35:0] t;
      y  = x;
      d  = '0;
      dv = 1'b0;
      t  = '0;
      if (x.dc < DCW'(MAX_DIGITS)) begin
         if (x.dc == '0) y.len = '0;
         y.dc = x.dc + 1'b1;
         if (!x.ne) begin
            if (c >= "0" && c <= "9") begin
               d  = 5'(c - "0");
               dv = 1'b1;
            end else if (hex && c >= "A" && c <= "F") begin
               d  = 5'(c - "A" + 8'd10);
               dv = 1'b1;
            end
            if (!dv) begin
               y.ne = 1'b1;
            end else begin
               if (hex) t = {y.len, 4'b0000} + 36'(d);
               else t = {1'b0, y.len, 3'b000} + {3'b000, y.len, 1'b0} + 36'(d);
               y.len = (t[35:32] != '0) ? 32'hFFFF_FFFF : t[31:0];
            end
         end
      end
      return y;
   endfunction

   function automatic ctx_type end_number(ctx_type x);
      ctx_type y;
      y = x;
      if (x.dc == '0) y.len = '0;
      y.fl = y.fl | hmbs_pkg::F_LEN;
      y.dc = '0;
      y.ne = 1'b0;
      return y;
   endfunction

   // walk the miss chain (at most five entries) then apply the action
   function automatic ctx_type run_tbl(ctx_type x, logic [7:0] cin, output logic [1:0] st);
      ctx_type                 y;
      logic [7:0]              c;
      logic [6:0]              i;
      logic                    found;
      logic [3:0]              act;
      hmbs_pkg::tbl_entry_type e;
      y     = x;
      st    = hmbs_pkg::ST_SEARCH;
      c     = cin;
      found = 1'b0;
      act   = hmbs_pkg::A_NOP;
      if (cin == hmbs_pkg::CH_TAB) c = hmbs_pkg::EV_LWS;
      else if (cin >= "a" && cin <= "z") c = cin - 8'd32;
      i = (x.ms < hmbs_pkg::TBL_SIZE) ? x.ms : hmbs_pkg::B9;
      for (int k = 0; k < 8; k++) begin
         if (!found) begin
            e = hmbs_pkg::tbl_entry(i);
            if (e.ev == hmbs_pkg::EV_ANY || e.ev == c) begin
               y.ms  = e.hit;
               act   = e.act;
               found = 1'b1;
            end else begin
               i    = e.miss;
               y.ms = e.miss;
            end
         end
      end
      case (act)
         hmbs_pkg::A_V0:   y.fl = y.fl | hmbs_pkg::F_V0;
         hmbs_pkg::A_V1:   y.fl = y.fl | hmbs_pkg::F_V1;
         hmbs_pkg::A_NOB:  y.fl = y.fl | hmbs_pkg::F_NOB;
         hmbs_pkg::A_RSP:  y.fl = y.fl | hmbs_pkg::F_RSP;
         hmbs_pkg::A_CHK:  y.fl = y.fl | hmbs_pkg::F_CHK;
         hmbs_pkg::A_DDIG: y = take_digit(y, c, 1'b0);
         hmbs_pkg::A_HDIG: y = take_digit(y, c, 1'b1);
         hmbs_pkg::A_DEND: y = end_number(y);
         hmbs_pkg::A_HEND: begin
            y = end_number(y);
            if (y.len != '0) begin
               st = hmbs_pkg::ST_SKIP;
            end else begin
               y.fl = y.fl & ~hmbs_pkg::F_NOF;
               y.lp = hmbs_pkg::LP_TRL;
            end
         end
         default: ;
      endcase
      return y;
   endfunction

   function automatic ctx_type end_hdrs(ctx_type x, output logic [1:0] st);
      ctx_type y;
      y = x;
      if ((x.fl & hmbs_pkg::F_NOB) != '0 && (x.fl & hmbs_pkg::F_RSP) != '0) begin
         y.len = '0;
         st    = hmbs_pkg::ST_FLUSH;
      end else if ((x.fl & hmbs_pkg::F_CHK) != '0) begin
         y.fl = (x.fl | hmbs_pkg::F_NOF) & ~hmbs_pkg::F_CHK;
         y.ms = hmbs_pkg::CHUNK_START;
         st   = hmbs_pkg::ST_SEARCH;
      end else if ((x.fl & (hmbs_pkg::F_REQ | hmbs_pkg::F_LEN)) != '0) begin
         st = hmbs_pkg::ST_FLUSH;
      end else begin
         st = hmbs_pkg::ST_ABORT;
      end
      return y;
   endfunction

   function automatic ctx_type scan_byte(ctx_type x, logic [7:0] c, output logic [1:0] st);
      ctx_type    y;
      logic [1:0] s0;
      y  = x;
      st = hmbs_pkg::ST_SEARCH;
      s0 = hmbs_pkg::ST_SEARCH;
      if (c != hmbs_pkg::CH_CR) begin
         case (x.lp)
            hmbs_pkg::LP_TEXT: begin
               if (c == hmbs_pkg::CH_LF) begin
                  if ((x.fl & hmbs_pkg::F_NOF) != '0) y = run_tbl(y, hmbs_pkg::EV_EOL, st);
                  else y.lp = hmbs_pkg::LP_EOL;
               end else begin
                  y = run_tbl(y, c, st);
               end
            end
            hmbs_pkg::LP_EOL: begin
               if (c == hmbs_pkg::CH_LF) begin
                  y = run_tbl(y, hmbs_pkg::EV_EOL, s0);
                  y = end_hdrs(y, st);
               end else if (c == hmbs_pkg::CH_SP || c == hmbs_pkg::CH_TAB) begin
                  y = run_tbl(y, hmbs_pkg::EV_LWS, st);
               end else begin
                  // header line ended without folding: close it, then scan the byte if closing gave no result
                  y = run_tbl(y, hmbs_pkg::EV_EOL, s0);
                  st = s0;
                  if (s0 == hmbs_pkg::ST_SEARCH) y = run_tbl(y, c, st);
               end
               y.lp = hmbs_pkg::LP_TEXT;
            end
            hmbs_pkg::LP_TRL: begin
               if (c == hmbs_pkg::CH_LF) y = end_hdrs(y, st);
               else y.lp = hmbs_pkg::LP_TRLTXT;
            end
            hmbs_pkg::LP_TRLTXT: begin
               if (c == hmbs_pkg::CH_LF) y.lp = hmbs_pkg::LP_TRL;
            end
            default: ;
         endcase
      end
      return y;
   endfunction

   ctx_type                ctx_ff, ctx_in, nx;
   logic                   seg_ff, seg_in, seg_nx;
   logic [31:0]            seen_ff, seen_in, seen_nx;
   logic [31:0]            cap_ff;
   logic                   ovld_ff, ovld_in;
   hmbs_pkg::rsp_word_type oword_ff, res;
   logic [1:0]             st;
   logic                   fire;

   assign in_take   = !ovld_ff || out_ready;
   assign fire      = in_valid && in_take;
   assign out_valid = ovld_ff;
   assign out_word  = oword_ff;

   always_comb begin
      nx      = ctx_ff;
      seg_nx  = seg_ff;
      seen_nx = seen_ff;
      st      = hmbs_pkg::ST_SEARCH;
      res     = '0;
      if (in_word.new_session) begin
         nx     = restart(in_word.from_client);
         seg_nx = 1'b1;
      end
      if (in_word.peer_head_seen) nx.fl = nx.fl | hmbs_pkg::F_NOB;
      if (seg_nx && cap_ff != '0 && seen_ff > cap_ff) begin
         // cap abort: byte not scanned or counted, next byte is a segment start
         res.status = hmbs_pkg::ST_ABORT;
      end else begin
         seg_nx = 1'b0;
         nx     = scan_byte(nx, in_word.byte_value, st);
         if (seen_ff != 32'hFFFF_FFFF) seen_nx = seen_ff + 32'd1;
         res.status = st;
         if (st != hmbs_pkg::ST_SEARCH) begin
            res.flush_offset       = nx.len;
            res.head_request_flush = ((nx.fl & (hmbs_pkg::F_NOB | hmbs_pkg::F_REQ))
                                      == (hmbs_pkg::F_NOB | hmbs_pkg::F_REQ));
            if (st != hmbs_pkg::ST_SKIP) nx = restart(in_word.from_client);
            seg_nx = 1'b1;
         end
         if (in_word.segment_last) seg_nx = 1'b1;
      end
   end

   always_comb begin
      ctx_in  = fire ? nx : ctx_ff;
      seg_in  = fire ? seg_nx : seg_ff;
      seen_in = fire ? seen_nx : seen_ff;
      ovld_in = fire ? 1'b1 : (out_ready ? 1'b0 : ovld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff  <= restart(1'b0);
         seg_ff  <= 1'b1;
         seen_ff <= '0;
         cap_ff  <= '0;
         ovld_ff <= 1'b0;
      end else begin
         ctx_ff  <= ctx_in;
         seg_ff  <= seg_in;
         seen_ff <= seen_in;
         ovld_ff <= ovld_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         oword_ff <= res;
      end
   end

   a_seen_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> seen_ff >= $past(seen_ff))
      else $error("byte counter went backwards");

   a_result_opens_segment: assert property (@(posedge clock) disable iff (reset)
      (fire && res.status != hmbs_pkg::ST_SEARCH) |=> seg_ff)
      else $error("segment start not set after a result");

   a_dir_mark: assert property (@(posedge clock) disable iff (reset)
      (ctx_ff.fl & (hmbs_pkg::F_REQ | hmbs_pkg::F_RSP)) != '0)
      else $error("message lost its direction mark");

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      ctx_ff.dc <= DCW'(MAX_DIGITS))
      else $error("digit count past limit");
endmodule

// File: verif/http_message_boundary_scanner_top_test.sv
// Testbench for http_message_boundary_scanner_top: drives byte words, predicts
// each status word and checks it. Depends on http_message_boundary_scanner_top, hmbs_pkg, hmbs_req_if, hmbs_rsp_if.
`timescale 1ns / 100ps

class hmbs_scoreboard;
   logic [31:0] byte_cap;
   logic [6:0]  match_state;
   logic [2:0]  line_phase;
   logic [7:0]  message_flags;
   logic [31:0] length_value;
   int          digit_count;
   bit          number_ended;
   logic [31:0] bytes_seen;
   bit          at_segment_start;
   hmbs_pkg::rsp_word_type pending[$];
   int          fail_count;

   function void clear();
      byte_cap = 0;
      restart(1'b0);
      bytes_seen = 0;
      at_segment_start = 1;
      pending.delete();
      fail_count = 0;
   endfunction

   function void restart(bit client);
      length_value = 0;
      line_phase = hmbs_pkg::LP_TEXT;
      digit_count = 0;
      number_ended = 0;
      match_state = client ? hmbs_pkg::REQ_START : hmbs_pkg::RSP_START;
      message_flags = client ? hmbs_pkg::F_REQ : hmbs_pkg::F_RSP;
   endfunction

   // match table entries, built from the keyword strings
   function void entry(int i, output logic [7:0] ev, output int hit, output int miss,
                       output int act);
      string txt;
      ev = 0; act = hmbs_pkg::A_NOP; hit = i + 1; miss = 67;
      if (i <= 8) begin
         txt = "HTTP/1.01";
         ev = txt[i];
         if (i == 0) miss = 65;
         if (i == 7) begin hit = 9; miss = 8; act = hmbs_pkg::A_V0; end
         if (i == 8) begin hit = 9; act = hmbs_pkg::A_V1; end
      end else if (i == 9) begin
         ev = hmbs_pkg::EV_LWS; hit = 67; act = hmbs_pkg::A_RSP;
      end else if (i <= 13) begin
         txt = "HEAD"; ev = txt[i-10];
         if (i == 10) miss = 15;
      end else if (i == 14) begin
         ev = hmbs_pkg::EV_LWS; hit = 67; act = hmbs_pkg::A_NOB;
      end else if (i <= 28) begin
         txt = "CONTENT-LENGTH"; ev = txt[i-15];
         if (i == 15) miss = 32;
      end else if (i == 29) begin ev = hmbs_pkg::EV_LWS; hit = 29; miss = 30;
      end else if (i == 30) begin ev = ":";
      end else if (i == 31) begin ev = hmbs_pkg::EV_LWS; hit = 31; miss = 59;
      end else if (i <= 48) begin
         txt = "TRANSFER-ENCODING"; ev = txt[i-32];
      end else if (i == 49) begin ev = hmbs_pkg::EV_LWS; hit = 49; miss = 50;
      end else if (i == 50) begin ev = ":";
      end else if (i == 51) begin ev = hmbs_pkg::EV_LWS; hit = 51; miss = 52;
      end else if (i <= 58) begin
         txt = "CHUNKED"; ev = txt[i-52];
         if (i == 58) begin hit = 67; act = hmbs_pkg::A_CHK; end
      end else begin
         case (i)
            59: begin ev = hmbs_pkg::EV_EOL; hit = 15; miss = 60; act = hmbs_pkg::A_DEND; end
            60: begin ev = hmbs_pkg::EV_ANY; hit = 59; miss = 59; act = hmbs_pkg::A_DDIG; end
            61: begin ev = hmbs_pkg::EV_EOL; hit = 63; miss = 62; act = hmbs_pkg::A_HEND; end
            62: begin ev = hmbs_pkg::EV_ANY; hit = 61; miss = 61; act = hmbs_pkg::A_HDIG; end
            63: begin ev = hmbs_pkg::EV_EOL; hit = 61; miss = 64; end
            64: begin ev = hmbs_pkg::EV_ANY; hit = 63; miss = 63; end
            65: begin ev = hmbs_pkg::EV_LWS; hit = 0; miss = 66; end
            66: begin ev = hmbs_pkg::EV_EOL; hit = 0; miss = 68; end
            67: begin ev = hmbs_pkg::EV_EOL; hit = 15; miss = 68; end
            default: begin ev = hmbs_pkg::EV_ANY; hit = 67; miss = 67; end
         endcase
      end
   endfunction

   function void take_digit(logic [7:0] c, int base);
      int d;
      logic [63:0] t;
      d = 99;
      if (digit_count >= hmbs_pkg::MAX_DIGITS_DEF) return;
      if (digit_count == 0) length_value = 0;
      digit_count++;
      if (number_ended) return;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (base == 16 && c >= "A" && c <= "F") d = c - "A" + 10;
      if (d >= base) number_ended = 1;
      else begin
         t = {32'd0, length_value} * base + d;
         length_value = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
      end
   endfunction

   function void end_number();
      if (digit_count == 0) length_value = 0;
      message_flags |= hmbs_pkg::F_LEN;
      digit_count = 0;
      number_ended = 0;
   endfunction

   function logic [1:0] walk(logic [7:0] c);
      int i, hit, miss, act, g;
      logic [7:0] ev;
      i = (match_state < 69) ? match_state : 67;
      act = hmbs_pkg::A_NOP;
      if (c == hmbs_pkg::CH_TAB) c = hmbs_pkg::EV_LWS;
      else if (c >= "a" && c <= "z") c -= 8'd32;
      for (g = 0; g < 69; g++) begin
         entry(i, ev, hit, miss, act);
         if (ev == hmbs_pkg::EV_ANY || ev == c) begin
            match_state = 7'(hit);
            break;
         end
         act = hmbs_pkg::A_NOP;
         i = miss;
         match_state = 7'(i);
      end
      case (act)
         hmbs_pkg::A_V0:   message_flags |= hmbs_pkg::F_V0;
         hmbs_pkg::A_V1:   message_flags |= hmbs_pkg::F_V1;
         hmbs_pkg::A_NOB:  message_flags |= hmbs_pkg::F_NOB;
         hmbs_pkg::A_RSP:  message_flags |= hmbs_pkg::F_RSP;
         hmbs_pkg::A_CHK:  message_flags |= hmbs_pkg::F_CHK;
         hmbs_pkg::A_DDIG: take_digit(c, 10);
         hmbs_pkg::A_HDIG: take_digit(c, 16);
         hmbs_pkg::A_DEND: end_number();
         hmbs_pkg::A_HEND: begin
            end_number();
            if (length_value != 0) return hmbs_pkg::ST_SKIP;
            message_flags &= ~hmbs_pkg::F_NOF;
            line_phase = hmbs_pkg::LP_TRL;
         end
         default: ;
      endcase
      return hmbs_pkg::ST_SEARCH;
   endfunction

   function logic [1:0] headers_done();
      if ((message_flags & hmbs_pkg::F_NOB) && (message_flags & hmbs_pkg::F_RSP)) begin
         length_value = 0;
         return hmbs_pkg::ST_FLUSH;
      end
      if (message_flags & hmbs_pkg::F_CHK) begin
         message_flags = (message_flags | hmbs_pkg::F_NOF) & ~hmbs_pkg::F_CHK;
         match_state = hmbs_pkg::CHUNK_START;
         return hmbs_pkg::ST_SEARCH;
      end
      if (message_flags & (hmbs_pkg::F_REQ | hmbs_pkg::F_LEN)) return hmbs_pkg::ST_FLUSH;
      return hmbs_pkg::ST_ABORT;
   endfunction

   function logic [1:0] scan(logic [7:0] c);
      logic [1:0] st;
      st = hmbs_pkg::ST_SEARCH;
      if (c == hmbs_pkg::CH_CR) return st;
      case (line_phase)
         hmbs_pkg::LP_TEXT: begin
            if (c == hmbs_pkg::CH_LF) begin
               if (message_flags & hmbs_pkg::F_NOF) st = walk(hmbs_pkg::EV_EOL);
               else line_phase = hmbs_pkg::LP_EOL;
            end else st = walk(c);
         end
         hmbs_pkg::LP_EOL: begin
            if (c == hmbs_pkg::CH_LF) begin
               void'(walk(hmbs_pkg::EV_EOL));
               st = headers_done();
            end else if (c == hmbs_pkg::CH_SP || c == hmbs_pkg::CH_TAB) begin
               st = walk(hmbs_pkg::EV_LWS);
            end else begin
               st = walk(hmbs_pkg::EV_EOL);
               if (st == hmbs_pkg::ST_SEARCH) st = walk(c);
            end
            line_phase = hmbs_pkg::LP_TEXT;
         end
         hmbs_pkg::LP_TRL: begin
            if (c == hmbs_pkg::CH_LF) st = headers_done();
            else line_phase = hmbs_pkg::LP_TRLTXT;
         end
         hmbs_pkg::LP_TRLTXT: if (c == hmbs_pkg::CH_LF) line_phase = hmbs_pkg::LP_TRL;
         default: ;
      endcase
      return st;
   endfunction

   function void note_byte(hmbs_pkg::req_word_type w);
      hmbs_pkg::rsp_word_type r;
      r = '0;
      if (w.new_session) begin
         restart(w.from_client);
         at_segment_start = 1;
      end
      if (w.peer_head_seen) message_flags |= hmbs_pkg::F_NOB;
      if (at_segment_start && byte_cap != 0 && bytes_seen > byte_cap) begin
         r.status = hmbs_pkg::ST_ABORT;
         pending.push_back(r);
         return;
      end
      at_segment_start = 0;
      r.status = scan(w.byte_value);
      if (bytes_seen != 32'hFFFFFFFF) bytes_seen++;
      if (r.status != hmbs_pkg::ST_SEARCH) begin
         r.flush_offset = length_value;
         r.head_request_flush = (message_flags & (hmbs_pkg::F_NOB | hmbs_pkg::F_REQ)) ==
                                (hmbs_pkg::F_NOB | hmbs_pkg::F_REQ);
         if (r.status != hmbs_pkg::ST_SKIP) restart(w.from_client);
         at_segment_start = 1;
      end
      if (w.segment_last) at_segment_start = 1;
      pending.push_back(r);
   endfunction

   function void check_status(hmbs_pkg::rsp_word_type got);
      hmbs_pkg::rsp_word_type e;
      if (pending.size() == 0) begin
         $error("unexpected status word %p", got);
         fail_count++;
         return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
         $error("status: expected %0d actual %0d", e.status, got.status);
         fail_count++;
      end
      if (got.flush_offset !== e.flush_offset) begin
         $error("flush_offset: expected %0d actual %0d", e.flush_offset, got.flush_offset);
         fail_count++;
      end
      if (got.head_request_flush !== e.head_request_flush) begin
         $error("head_request_flush: expected %0d actual %0d", e.head_request_flush,
                got.head_request_flush);
         fail_count++;
      end
   endfunction
endclass

module http_message_boundary_scanner_top_test;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [31:0] csr_wr_data = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   longint      cycle_count = 0;
   hmbs_scoreboard sb;

   hmbs_req_if req_chan();
   hmbs_rsp_if rsp_chan();

   http_message_boundary_scanner_top DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      hmbs_pkg::rsp_word_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status = rsp_chan.status;
            got.flush_offset = rsp_chan.flush_offset;
            got.head_request_flush = rsp_chan.head_request_flush;
            sb.check_status(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
      end else begin
         rsp_chan.ready <= 1'b0;
      end
   end

   task automatic send_phase_mode(int s, int r);
      send_idle = s;
      recv_idle = r;
   endtask

   // one word per call; random idle cycles before it as the sender pattern says
   task automatic send_byte(logic [7:0] b, bit client, bit fresh, bit last, bit peer);
      hmbs_pkg::req_word_type w;
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      w = '{b, client, fresh, last, peer};
      req_chan.valid <= 1;
      req_chan.byte_value <= b;
      req_chan.from_client <= client;
      req_chan.new_session <= fresh;
      req_chan.segment_last <= last;
      req_chan.peer_head_seen <= peer;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_byte(w);
   endtask

   task automatic send_text(string s, bit client, bit fresh);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], client, fresh && i == 0, $urandom_range(15) == 0,
                   $urandom_range(63) == 0);
   endtask

   task automatic drain_and_write(logic [31:0] cap);
      req_chan.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.byte_cap = cap;
   endtask

   function automatic string mixcase(string s);
      string o;
      o = s;
      for (int i = 0; i < o.len(); i++)
         if (o[i] >= "A" && o[i] <= "Z" && $urandom_range(1)) o[i] = o[i] + 8'd32;
      return o;
   endfunction

   task automatic random_message();
      bit client;
      int k;
      string s;
      client = 1'($urandom_range(1));
      s = client ? ($urandom_range(1) ? "HEAD / HTTP/1.1\r\n" : "GET /x HTTP/1.1\r\n")
                 : ($urandom_range(1) ? "HTTP/1.1 200 OK\r\n" : "HTTP/1.0 404 NF\r\n");
      k = $urandom_range(5);
      if (k == 0) s = {s, "Content-Length: ", $sformatf("%0d", $urandom_range(99999)), "\r\n"};
      else if (k == 1) s = {s, "Content-Length:", $sformatf("%0d", $urandom), "x\r\n"};
      else if (k == 2) s = {s, "Transfer-Encoding: chunked\r\n"};
      else if (k == 3) s = {s, "X-A: b\r\n  folded\r\n"};
      s = {mixcase(s), "\r\n"};
      if (k == 2) s = {s, $sformatf("%0h\r\n", $urandom_range(4095)), "0\r\nT: 1\r\n\r\n"};
      send_text(s, client, $urandom_range(3) == 0);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 2) begin
            repeat ($urandom_range(8, 1))
               send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                         $urandom_range(7) == 0, $urandom_range(3) == 0,
                         $urandom_range(7) == 0);
         end else random_message();
      end
   endtask

   initial begin
      req_chan.valid <= 0;
      req_chan.byte_value <= 0;
      req_chan.from_client <= 0;
      req_chan.new_session <= 0;
      req_chan.segment_last <= 0;
      req_chan.peer_head_seen <= 0;
      sb = new();
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_phase_mode(27, 61);
      // directed: extremes, HEAD round trip, digit overflow, hex chunk, noise
      send_text("HEAD / HTTP/1.1\r\n\r\n", 1'b1, 1'b1);
      send_byte(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1, 1'b0, 1'b1);
      send_byte(8'h0A, 1'b1, 1'b0, 1'b0, 1'b0);
      send_byte(8'h0A, 1'b1, 1'b0, 1'b1, 1'b0);
      send_text("HTTP/1.0 200\ncontent-length: 99999999\n\n", 1'b0, 1'b1);
      send_text("http/1.1 x\ntransfer-encoding:\tchunked\n\nfFfFfFfFf\n0\n\n", 1'b0, 1'b1);
      drain_and_write(32'd1);
      send_text("abcd", 1'b0, 1'b1);
      drain_and_write(32'hFFFFFFFF);
      random_phase(8);
      drain_and_write(32'd3000);
      random_phase(7);
      send_phase_mode(61, 27);
      drain_and_write(32'd0);
      random_phase(8);
      drain_and_write($urandom_range(32'h7FFFFFFF, 1));
      send_phase_mode(0, 0);
      random_phase(8);
      req_chan.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// File: files.f
rtl/hmbs_pkg.sv
rtl/hmbs_req_if.sv
rtl/hmbs_rsp_if.sv
rtl/hmbs_input_reg.sv
rtl/hmbs_scan_core.sv
rtl/http_message_boundary_scanner_top.sv
verif/http_message_boundary_scanner_top_test.sv
